// File: design/dtsi_pkg.sv
// Shared types and constants for the decimal text to scaled integer parser.
`timescale 1ns / 1ps

package dtsi_pkg;

  // Parse phase of the current text
  typedef enum logic [1:0] {
    PH_START  = 2'd0,  // skipping whitespace
    PH_SIGNED = 2'd1,  // sign seen, digit required
    PH_BODY   = 2'd2,  // in the number body
    PH_BAD    = 2'd3   // malformed, waiting for the final character
  } phase_t;

  localparam int CHAR_W = 8;
  localparam int MAG_W  = 60;
  localparam int MANT_W = 61;
  localparam int CNT_W  = 5;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

endpackage

// File: design/decimal_text_to_scaled_integer.sv
// Top level: streaming parser from decimal text to a signed mantissa and scale.
`timescale 1ns / 1ps

// Usage
//   Character channel: char_valid / char_stall carry one character a beat
//   (char_code) with last set on the final character of a text.
//   Result channel: result_valid / result_stall carry one beat per text,
//   issued for the beat that had last set: well_formed, mantissa (signed,
//   dot removed), frac_digits (value = mantissa / 10^frac_digits) and
//   overflow (digits past MAX_DIGITS were dropped). Malformed text gives
//   all-zero fields.
// Timing
//   A character beat is captured in an input register; the parse state and
//   the result register update when that beat is consumed, so result_valid
//   rises in the cycle after the final character is consumed. The block
//   takes one character every cycle while char_stall is low; the only work
//   per beat is a multiply-by-ten accumulate (two shifted adds) and a phase update.
// Stall
//   While a result waits on result_stall, characters that produce no result
//   keep flowing; a final character waits in the input register, and only
//   then is char_stall raised.
// Reset: rst (synchronous) empties both registers and restarts the parser.
module decimal_text_to_scaled_integer #(
  parameter int MAX_DIGITS = 18
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  logic [dtsi_pkg::CHAR_W-1:0]     char_code,
  input  logic                            last,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            well_formed,
  output logic signed [dtsi_pkg::MANT_W-1:0] mantissa,
  output logic [dtsi_pkg::CNT_W-1:0]      frac_digits,
  output logic                            overflow
);

  localparam logic [dtsi_pkg::CNT_W-1:0] DIGIT_LIMIT = dtsi_pkg::CNT_W'(MAX_DIGITS);

  // Input register
  logic                        s1_valid;
  logic [dtsi_pkg::CHAR_W-1:0] s1_char;
  logic                        s1_last;
  logic                        s1_consume;

  // Parse state
  dtsi_pkg::phase_t            phase, phase_next;
  logic                        is_negative, is_negative_next;
  logic [dtsi_pkg::MAG_W-1:0]  magnitude, magnitude_next;
  logic [dtsi_pkg::CNT_W-1:0]  digit_count, digit_count_next;
  logic [dtsi_pkg::CNT_W-1:0]  fraction_count, fraction_count_next;
  logic                        dot_seen, dot_seen_next;
  logic                        overflowed, overflowed_next;

  // Result of the beat being processed
  logic                        res_well_formed;
  logic [dtsi_pkg::MANT_W-1:0] res_mantissa;

  // Consume a beat unless it makes a result and the result slot stays full.
  assign s1_consume = s1_valid && (!s1_last || !result_valid || !result_stall);
  assign char_stall = s1_valid && !s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      s1_char <= char_code;
      s1_last <= last;
    end
  end

  // Character classes and digit accumulate for the beat in the input register
  always_comb begin
    logic                       blank;
    logic                       digit;
    logic [3:0]                 dval;
    logic                       keep;
    logic [dtsi_pkg::MAG_W-1:0] mag_x10;
    logic [dtsi_pkg::MAG_W-1:0] mag_acc;
    logic                       take;

    blank = (s1_char == dtsi_pkg::CH_SPACE) ||
            (s1_char >= dtsi_pkg::CH_TAB && s1_char <= dtsi_pkg::CH_CR);
    digit = (s1_char >= dtsi_pkg::CH_ZERO) && (s1_char <= dtsi_pkg::CH_NINE);
    dval  = 4'(s1_char - dtsi_pkg::CH_ZERO);
    // Integer leading zeros are neither kept nor counted
    keep  = !(dval == 4'd0 && magnitude == '0 && !dot_seen);
    mag_x10 = {magnitude[dtsi_pkg::MAG_W-4:0], 3'b000} +
              {magnitude[dtsi_pkg::MAG_W-2:0], 1'b0};
    mag_acc = mag_x10 + dtsi_pkg::MAG_W'(dval);
    take  = 1'b0;

    phase_next          = phase;
    is_negative_next    = is_negative;
    magnitude_next      = magnitude;
    digit_count_next    = digit_count;
    fraction_count_next = fraction_count;
    dot_seen_next       = dot_seen;
    overflowed_next     = overflowed;

    unique case (phase)
      dtsi_pkg::PH_START: begin
        if (blank) begin
          phase_next = dtsi_pkg::PH_START;
        end else if (s1_char == dtsi_pkg::CH_MINUS || s1_char == dtsi_pkg::CH_PLUS) begin
          is_negative_next = (s1_char == dtsi_pkg::CH_MINUS);
          phase_next       = dtsi_pkg::PH_SIGNED;
        end else if (digit) begin
          take       = 1'b1;
          phase_next = dtsi_pkg::PH_BODY;
        end else begin
          phase_next = dtsi_pkg::PH_BAD;
        end
      end
      dtsi_pkg::PH_SIGNED: begin
        if (digit) begin
          take       = 1'b1;
          phase_next = dtsi_pkg::PH_BODY;
        end else begin
          phase_next = dtsi_pkg::PH_BAD;
        end
      end
      dtsi_pkg::PH_BODY: begin
        if (digit) begin
          take = 1'b1;
        end else if (s1_char == dtsi_pkg::CH_DOT && !dot_seen) begin
          dot_seen_next = 1'b1;
        end else begin
          phase_next = dtsi_pkg::PH_BAD;
        end
      end
      dtsi_pkg::PH_BAD: begin
        phase_next = dtsi_pkg::PH_BAD;
      end
      default: begin
        phase_next = dtsi_pkg::PH_BAD;
      end
    endcase

    if (take && keep) begin
      if (digit_count >= DIGIT_LIMIT) begin
        overflowed_next = 1'b1;
      end else begin
        magnitude_next   = mag_acc;
        digit_count_next = digit_count + 1'b1;
        if (dot_seen) begin
          fraction_count_next = fraction_count + 1'b1;
        end
      end
    end

    res_well_formed = (phase_next == dtsi_pkg::PH_BODY);
    res_mantissa    = is_negative_next ? (~{1'b0, magnitude_next} + 1'b1)
                                       : {1'b0, magnitude_next};
  end

  // Parse state register: advance on each consumed beat, restart after last
  always_ff @(posedge clk) begin
    if (rst || (s1_consume && s1_last)) begin
      phase          <= dtsi_pkg::PH_START;
      is_negative    <= 1'b0;
      magnitude      <= '0;
      digit_count    <= '0;
      fraction_count <= '0;
      dot_seen       <= 1'b0;
      overflowed     <= 1'b0;
    end else if (s1_consume) begin
      phase          <= phase_next;
      is_negative    <= is_negative_next;
      magnitude      <= magnitude_next;
      digit_count    <= digit_count_next;
      fraction_count <= fraction_count_next;
      dot_seen       <= dot_seen_next;
      overflowed     <= overflowed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_consume && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_consume && s1_last) begin
      well_formed <= res_well_formed;
      mantissa    <= res_well_formed ? res_mantissa : '0;
      frac_digits <= res_well_formed ? fraction_count_next : '0;
      overflow    <= res_well_formed ? overflowed_next : 1'b0;
    end
  end

  // A malformed text reports all-zero fields.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !well_formed) |-> (mantissa == '0 && frac_digits == '0 && !overflow))
    else $error("malformed result carries nonzero fields");

  // Kept digit counts never pass the limit, fraction within kept digits.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (digit_count <= DIGIT_LIMIT) && (fraction_count <= digit_count))
    else $error("digit counters out of range");

  // The parser restarts after every final character.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_consume && s1_last) |=> (phase == dtsi_pkg::PH_START && magnitude == '0 && !dot_seen))
    else $error("parser did not restart after final character");

  // Nothing is kept before the first digit has been seen.
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == dtsi_pkg::PH_START || phase == dtsi_pkg::PH_SIGNED) |->
      (magnitude == '0 && digit_count == '0 && !dot_seen))
    else $error("state held before first digit");

endmodule
